/* hdl/cwtc_pkg.sv */
// shared types and constants of the charge walk time correction block
`default_nettype none
package cwtc_pkg;

  // item function codes
  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_CORRECT = 1'b1
  } func_e;

  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned COEF_BITS  = 32;
  localparam int unsigned FRAC_BITS  = 24;
  // inverse root in q1.24, range 0 to 2^24
  localparam int unsigned INV_BITS   = FRAC_BITS + 1;
  // quotient bits of 2^48 / q
  localparam int unsigned DIV_STEPS  = 2 * FRAC_BITS + 1;
  // root digits of the quotient
  localparam int unsigned SQRT_STEPS = INV_BITS;
  localparam int unsigned INV_LAT    = DIV_STEPS + SQRT_STEPS;
  localparam int unsigned W_BITS     = INV_BITS + 1;
  localparam int unsigned PROD_BITS  = COEF_BITS + W_BITS;

  // control that travels beside the datapath
  typedef struct packed {
    logic valid;
    logic zero;
  } post_ctl_t;

endpackage
`default_nettype wire

/* hdl/cwtc_coef_mem.sv */
// coefficient table memory with clearing sweep after reset
`default_nettype none
module cwtc_coef_mem #(
  parameter int unsigned NUM_PMS = 256,
  parameter int unsigned AW      = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           we_i,
  input  wire logic [AW-1:0]                  waddr_i,
  input  wire logic [cwtc_pkg::COEF_BITS-1:0] wdata_i,
  input  wire logic [AW-1:0]                  raddr_i,
  output logic      [cwtc_pkg::COEF_BITS-1:0] rdata_o,
  output logic                                clearing_o
);

  logic [cwtc_pkg::COEF_BITS-1:0] mem [NUM_PMS];
  logic [AW-1:0] clr_idx_q, clr_idx_d;
  logic          clearing_q, clearing_d;

  always_comb begin
    clr_idx_d  = clr_idx_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_idx_d = clr_idx_q + AW'(1);
      if (clr_idx_q == AW'(NUM_PMS - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_idx_q  <= clr_idx_d;
      clearing_q <= clearing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_idx_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

  assign clearing_o = clearing_q;

endmodule
`default_nettype wire

/* hdl/cwtc_inv_sqrt.sv */
// pipelined exact floor(2^24 / sqrt(q)): restoring divide then digit root
`default_nettype none
module cwtc_inv_sqrt #(
  parameter int unsigned CHARGE_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic [CHARGE_BITS-1:0]        q_i,
  output logic      [cwtc_pkg::INV_BITS-1:0] inv_o
);

  localparam int unsigned DS  = cwtc_pkg::DIV_STEPS;
  localparam int unsigned SS  = cwtc_pkg::SQRT_STEPS;
  localparam int unsigned IB  = cwtc_pkg::INV_BITS;
  localparam int unsigned RW  = CHARGE_BITS + 1;
  localparam int unsigned SRW = IB + 3;

  logic [RW-1:0]          drem_q [DS];
  logic [CHARGE_BITS-1:0] dq_q   [DS];
  logic [DS-1:0]          quo_q  [DS];

  logic [SRW-1:0] srem_q [SS];
  logic [IB-1:0]  root_q [SS];
  logic [DS-1:0]  rad_q  [SS];

  for (genvar s = 0; s < DS; s++) begin : g_div
    logic [RW-1:0]          rem_in;
    logic [CHARGE_BITS-1:0] q_in;
    logic [DS-1:0]          quo_in;
    logic [RW-1:0]          part;
    logic                   ge;
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = q_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = drem_q[s-1];
      assign q_in   = dq_q[s-1];
      assign quo_in = quo_q[s-1];
    end
    // dividend is a single one at its top bit
    assign part = {rem_in[RW-2:0], 1'(s == 0)};
    assign ge   = part >= {1'b0, q_in};
    always_ff @(posedge clk_i) begin
      drem_q[s] <= ge ? part - {1'b0, q_in} : part;
      dq_q[s]   <= q_in;
      quo_q[s]  <= {quo_in[DS-2:0], ge};
    end
  end

  for (genvar j = 0; j < SS; j++) begin : g_sqrt
    logic [SRW-1:0] rem_in;
    logic [IB-1:0]  root_in;
    logic [DS-1:0]  rad_in;
    logic [DS:0]    rad_ext;
    logic [SRW-1:0] part;
    logic [SRW-1:0] trial;
    logic           ge;
    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = quo_q[DS-1];
    end else begin : g_next
      assign rem_in  = srem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
    end
    assign rad_ext = {1'b0, rad_in};
    assign part    = {rem_in[SRW-3:0], rad_ext[DS-2*j -: 2]};
    assign trial   = SRW'({root_in, 2'b01});
    assign ge      = part >= trial;
    always_ff @(posedge clk_i) begin
      srem_q[j] <= ge ? part - trial : part;
      root_q[j] <= {root_in[IB-2:0], ge};
      rad_q[j]  <= rad_in;
    end
  end

  assign inv_o = root_q[SS-1];

endmodule
`default_nettype wire

/* hdl/cwtc_post.sv */
// walk term, coefficient product, rounding and saturation
`default_nettype none
module cwtc_post (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire cwtc_pkg::post_ctl_t                  ctl_i,
  input  wire logic signed [cwtc_pkg::TIME_BITS-1:0] td_i,
  input  wire logic signed [cwtc_pkg::COEF_BITS-1:0] coef_i,
  input  wire logic        [cwtc_pkg::INV_BITS-1:0]  inv_a_i,
  input  wire logic        [cwtc_pkg::INV_BITS-1:0]  inv_b_i,
  output logic                                      done_o,
  output logic signed      [cwtc_pkg::TIME_BITS-1:0] time_o,
  output logic                                      zero_o,
  output logic                                      sat_o
);

  localparam int unsigned TB = cwtc_pkg::TIME_BITS;
  localparam int unsigned PB = cwtc_pkg::PROD_BITS;
  localparam int unsigned FB = cwtc_pkg::FRAC_BITS;
  localparam int unsigned CB = PB + 1 - FB;
  localparam int unsigned DB = CB + 1;

  cwtc_pkg::post_ctl_t ctl1_q, ctl2_q;
  logic signed [TB-1:0]                  td1_q, td2_q;
  logic signed [cwtc_pkg::COEF_BITS-1:0] coef1_q;
  logic signed [cwtc_pkg::W_BITS-1:0]    w1_q;
  logic signed [PB-1:0]                  prod_q;

  logic signed [PB:0]   psum;
  logic signed [CB-1:0] corr;
  logic signed [DB-1:0] diff;
  logic                 ovf;
  logic signed [TB-1:0] time_d;
  logic                 sat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      done_o <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      done_o <= ctl2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    td1_q   <= td_i;
    coef1_q <= coef_i;
    w1_q    <= $signed({1'b0, inv_a_i}) - $signed({1'b0, inv_b_i});
    td2_q   <= td1_q;
    prod_q  <= coef1_q * w1_q;
  end

  // round half up, then floor shift
  always_comb begin
    psum   = {prod_q[PB-1], prod_q} + (PB+1)'(1 << (FB - 1));
    corr   = psum[PB:FB];
    diff   = DB'(td2_q) - DB'(corr);
    ovf    = (diff[DB-1:TB-1] != '0) && (diff[DB-1:TB-1] != '1);
    sat_d  = 1'b0;
    time_d = diff[TB-1:0];
    if (ctl2_q.zero) begin
      time_d = td2_q;
    end else if (ovf) begin
      sat_d  = 1'b1;
      time_d = diff[DB-1] ? {1'b1, {(TB-1){1'b0}}} : {1'b0, {(TB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    time_o <= time_d;
    zero_o <= ctl2_q.zero;
    sat_o  <= sat_d;
  end

endmodule
`default_nettype wire

/* hdl/charge_walk_time_correction_core.sv */
// top level of the charge walk time correction block
//
//  channel   | handshake          | fields
//  ----------+--------------------+----------------------------------------------
//  item in   | start_i / busy_o   | func, pm_id, charge_a/b, time_diff, coef_value
//  result    | done_o (strobe)    | corrected_time, zero_charge, saturated
//
// one item accepted per cycle whenever busy_o is low
// a correct item gives its result through 49 divide
//   steps and 25 root digits of the inverse square root pipeline, then
//   walk term and product stages and the output register
// load items with an id in range write the table at once and give no result
// after reset busy_o stays high while the table is swept to zero
// the receiver cannot stall, so nothing ever holds the pipeline
`default_nettype none
module charge_walk_time_correction_core #(
  parameter int unsigned NUM_PMS     = 256,
  parameter int unsigned CHARGE_BITS = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic                     func_i,
  input  wire logic [7:0]               pm_id_i,
  input  wire logic [CHARGE_BITS-1:0]   charge_a_i,
  input  wire logic [CHARGE_BITS-1:0]   charge_b_i,
  input  wire logic signed [31:0]       time_diff_i,
  input  wire logic signed [31:0]       coef_value_i,
  output logic                          done_o,
  output logic signed [31:0]            corrected_time_o,
  output logic                          zero_charge_o,
  output logic                          saturated_o
);

  localparam int unsigned AW  = (NUM_PMS > 1) ? $clog2(NUM_PMS) : 1;
  localparam int unsigned LAT = cwtc_pkg::INV_LAT;

  logic                 accept;
  logic                 in_range;
  logic                 is_correct;
  logic [AW-1:0]        addr;
  logic [31:0]          rdata;
  logic                 clearing;
  logic [cwtc_pkg::INV_BITS-1:0] inv_a, inv_b;

  // side line beside the inverse root pipeline
  logic                 sb_valid_q [LAT];
  logic                 sb_zero_q  [LAT];
  logic                 sb_range_q [LAT];
  logic signed [31:0]   sb_td_q    [LAT];
  logic signed [31:0]   cq_q       [1:LAT-1];

  cwtc_pkg::post_ctl_t  post_ctl;

  assign accept     = start_i && !busy_o;
  assign is_correct = (cwtc_pkg::func_e'(func_i) == cwtc_pkg::FUNC_CORRECT);
  assign in_range   = 32'(pm_id_i) < NUM_PMS;
  assign addr       = AW'(pm_id_i);
  assign busy_o     = clearing;

  // table: written on accepted loads with an id in range, read on every accepted item
  cwtc_coef_mem #(
    .NUM_PMS (NUM_PMS),
    .AW      (AW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (accept && !is_correct && in_range),
    .waddr_i    (addr),
    .wdata_i    (coef_value_i),
    .raddr_i    (addr),
    .rdata_o    (rdata),
    .clearing_o (clearing)
  );

  cwtc_inv_sqrt #(.CHARGE_BITS(CHARGE_BITS)) u_inv_a (
    .clk_i (clk_i),
    .q_i   (charge_a_i),
    .inv_o (inv_a)
  );

  cwtc_inv_sqrt #(.CHARGE_BITS(CHARGE_BITS)) u_inv_b (
    .clk_i (clk_i),
    .q_i   (charge_b_i),
    .inv_o (inv_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) begin
        sb_valid_q[k] <= 1'b0;
      end
    end else begin
      sb_valid_q[0] <= accept && is_correct;
      for (int k = 1; k < LAT; k++) begin
        sb_valid_q[k] <= sb_valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sb_zero_q[0]  <= (charge_a_i == '0) || (charge_b_i == '0);
    sb_range_q[0] <= in_range;
    sb_td_q[0]    <= time_diff_i;
    for (int k = 1; k < LAT; k++) begin
      sb_zero_q[k]  <= sb_zero_q[k-1];
      sb_range_q[k] <= sb_range_q[k-1];
      sb_td_q[k]    <= sb_td_q[k-1];
    end
    // out-of-range ids use a zero coefficient
    cq_q[1] <= sb_range_q[0] ? rdata : '0;
    for (int k = 2; k < LAT; k++) begin
      cq_q[k] <= cq_q[k-1];
    end
  end

  assign post_ctl.valid = sb_valid_q[LAT-1];
  assign post_ctl.zero  = sb_zero_q[LAT-1];

  cwtc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (post_ctl),
    .td_i    (sb_td_q[LAT-1]),
    .coef_i  (cq_q[LAT-1]),
    .inv_a_i (inv_a),
    .inv_b_i (inv_b),
    .done_o  (done_o),
    .time_o  (corrected_time_o),
    .zero_o  (zero_charge_o),
    .sat_o   (saturated_o)
  );

endmodule
`default_nettype wire

/* hdl/cwtc_checker.sv */
// port checker for the charge walk time correction block, with its bind
`default_nettype none
module cwtc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        busy_i,
  input wire logic        done_i,
  input wire logic [31:0] corrected_time_i,
  input wire logic        zero_charge_i,
  input wire logic        saturated_i
);

  // no result can come out of the table sweep
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |-> !done_i) else $error("result during table sweep");

  // the sweep runs once after reset
  a_busy_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_i |=> !busy_i) else $error("busy rose again");

  a_zero_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && zero_charge_i) |-> !saturated_i) else $error("zero charge flagged saturated");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && saturated_i) |->
      (corrected_time_i == 32'h7fff_ffff) || (corrected_time_i == 32'h8000_0000))
    else $error("saturated result not at a bound");

endmodule

bind charge_walk_time_correction_core cwtc_checker u_cwtc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .busy_i           (busy_o),
  .done_i           (done_o),
  .corrected_time_i (corrected_time_o),
  .zero_charge_i    (zero_charge_o),
  .saturated_i      (saturated_o)
);
`default_nettype wire

/* dv/charge_walk_time_correction_checker.sv */
// checker that predicts and compares the results of the walk correction block
`default_nettype none
module charge_walk_time_correction_checker #(
  parameter int unsigned NUM_PMS     = 256,
  parameter int unsigned CHARGE_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic                   busy_i,
  input  wire logic                   func_i,
  input  wire logic [7:0]             pm_id_i,
  input  wire logic [CHARGE_BITS-1:0] charge_a_i,
  input  wire logic [CHARGE_BITS-1:0] charge_b_i,
  input  wire logic signed [31:0]     time_diff_i,
  input  wire logic signed [31:0]     coef_value_i,
  input  wire logic                   done_i,
  input  wire logic signed [31:0]     corrected_time_i,
  input  wire logic                   zero_charge_i,
  input  wire logic                   saturated_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          result_count_o
);

  typedef struct packed {
    logic signed [31:0] corrected_time;
    logic               zero_charge;
    logic               saturated;
  } hit_result_t;

  logic signed [31:0] coef_shadow [NUM_PMS];
  hit_result_t        expected_hits [$];

  // largest r in [0, 2^24] with r*r*q <= 2^48
  function automatic longint inv_root_q24(longint unsigned q);
    longint unsigned limit, lo, hi, mid;
    limit = (64'd1 << 48) / q;
    lo = 0;
    hi = 64'd1 << 24;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid <= limit) lo = mid;
      else hi = mid - 1;
    end
    return longint'(lo);
  endfunction

  function automatic hit_result_t correct_hit(logic [7:0] pm, logic [CHARGE_BITS-1:0] qa,
                                             logic [CHARGE_BITS-1:0] qb,
                                             logic signed [31:0] td);
    hit_result_t r;
    longint coef, w, p, corr, diff;
    r.zero_charge = 1'b0;
    r.saturated   = 1'b0;
    if (qa == 0 || qb == 0) begin
      r.corrected_time = td;
      r.zero_charge    = 1'b1;
      return r;
    end
    coef = (pm < NUM_PMS) ? longint'(coef_shadow[pm]) : 0;
    w    = inv_root_q24(qa) - inv_root_q24(qb);
    p    = coef * w;
    corr = (p + (64'sd1 <<< 23)) >>> 24; // arithmetic shift floors
    diff = longint'(td) - corr;
    if (diff > 64'sd2147483647) begin
      r.corrected_time = 32'sh7fffffff;
      r.saturated      = 1'b1;
    end else if (diff < -64'sd2147483648) begin
      r.corrected_time = 32'sh80000000;
      r.saturated      = 1'b1;
    end else begin
      r.corrected_time = diff[31:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PMS; i++) coef_shadow[i] = '0;
      expected_hits.delete();
      fail_count_o   <= 0;
      result_count_o <= 0;
      pending_o      <= 0;
    end else begin
      if (done_i) begin
        result_count_o <= result_count_o + 1;
        if (expected_hits.size() == 0) begin
          $error("unexpected result: corrected_time %0d", corrected_time_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_hits.pop_front();
          if (want.corrected_time !== corrected_time_i ||
              want.zero_charge !== zero_charge_i || want.saturated !== saturated_i) begin
            fail_count_o <= fail_count_o + 1;
            if (want.corrected_time !== corrected_time_i)
              $error("corrected_time expected %0d actual %0d",
                     want.corrected_time, corrected_time_i);
            if (want.zero_charge !== zero_charge_i)
              $error("zero_charge expected %0b actual %0b", want.zero_charge, zero_charge_i);
            if (want.saturated !== saturated_i)
              $error("saturated expected %0b actual %0b", want.saturated, saturated_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        if (func_i == cwtc_pkg::FUNC_LOAD) begin
          if (pm_id_i < NUM_PMS) coef_shadow[pm_id_i] = coef_value_i;
        end else begin
          expected_hits.push_back(correct_hit(pm_id_i, charge_a_i, charge_b_i, time_diff_i));
        end
      end
      pending_o <= expected_hits.size();
    end
  end

endmodule
`default_nettype wire

/* dv/charge_walk_time_correction_core_tb.sv */
// stimulus and verdict for the charge walk time correction block
`default_nettype none
module charge_walk_time_correction_core_tb;

  localparam int unsigned NUM_PMS     = 256;
  localparam int unsigned CHARGE_BITS = 24;
  // pipeline depth of a correct item plus margin
  localparam int DRAIN_CYCLES = 120;
  // cycles without any accepted item or result before giving up
  localparam int STALL_LIMIT  = 4000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic                   func_i = cwtc_pkg::FUNC_LOAD;
  logic [7:0]             pm_id_i = '0;
  logic [CHARGE_BITS-1:0] charge_a_i = '0;
  logic [CHARGE_BITS-1:0] charge_b_i = '0;
  logic signed [31:0]     time_diff_i = '0;
  logic signed [31:0]     coef_value_i = '0;
  logic                   done_o;
  logic signed [31:0]     corrected_time_o;
  logic                   zero_charge_o;
  logic                   saturated_o;

  int fail_count, pending, result_count;
  int quiet_cycles = 0;
  int hit_items = 0, load_items = 0;
  bit calm_stretch = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  charge_walk_time_correction_core #(
    .NUM_PMS(NUM_PMS), .CHARGE_BITS(CHARGE_BITS)
  ) DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .pm_id_i, .charge_a_i, .charge_b_i,
    .time_diff_i, .coef_value_i, .done_o, .corrected_time_o, .zero_charge_o, .saturated_o
  );

  charge_walk_time_correction_checker #(
    .NUM_PMS(NUM_PMS), .CHARGE_BITS(CHARGE_BITS)
  ) u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .func_i, .pm_id_i, .charge_a_i,
    .charge_b_i, .time_diff_i, .coef_value_i, .done_i(done_o),
    .corrected_time_i(corrected_time_o), .zero_charge_i(zero_charge_o),
    .saturated_i(saturated_o), .fail_count_o(fail_count), .pending_o(pending),
    .result_count_o(result_count)
  );

  // watchdog: any acceptance or result counts as progress
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // random charge: mostly uniform over the full range, sometimes tiny, small, top or zero
  function automatic logic [CHARGE_BITS-1:0] pick_charge();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CHARGE_BITS'($urandom_range(1, 4));
      2:       return {CHARGE_BITS{1'b1}} - CHARGE_BITS'($urandom_range(0, 3));
      3:       return CHARGE_BITS'($urandom_range(1, 255));
      default: return CHARGE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff - $urandom_range(0, 1000);
      1:       return 32'sh80000000 + $urandom_range(0, 1000);
      2:       return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // hand one item over and hold it until accepted; random gaps before it
  task automatic send_item(logic func, logic [7:0] pm, logic [CHARGE_BITS-1:0] qa,
                           logic [CHARGE_BITS-1:0] qb, logic signed [31:0] td,
                           logic signed [31:0] coef);
    while (!calm_stretch && $urandom_range(0, 99) < 34) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    func_i       <= func;
    pm_id_i      <= pm;
    charge_a_i   <= qa;
    charge_b_i   <= qb;
    time_diff_i  <= td;
    coef_value_i <= coef;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (func == cwtc_pkg::FUNC_LOAD) load_items++;
    else hit_items++;
  endtask

  initial begin
    logic [CHARGE_BITS-1:0] qa, qb;
    logic [7:0] pm;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unloaded table, then extreme coefficients and charges
    send_item(cwtc_pkg::FUNC_CORRECT, 8'd0, 24'd1, 24'hffffff, 32'sd1000, '0);
    send_item(cwtc_pkg::FUNC_LOAD, 8'd0, '0, '0, '0, 32'sh7fffffff);
    send_item(cwtc_pkg::FUNC_LOAD, 8'd255, 24'hffffff, 24'hffffff, 32'shffffffff,
              32'sh80000000);
    send_item(cwtc_pkg::FUNC_LOAD, 8'd7, '0, '0, '0, 32'sd256);
    // extreme times against near-full corrections of the same sign, so neither clamps
    send_item(cwtc_pkg::FUNC_CORRECT, 8'd0, 24'd1, 24'hffffff, 32'sh7fffffff, '0);
    send_item(cwtc_pkg::FUNC_CORRECT, 8'd0, 24'hffffff, 24'd1, 32'sh80000000, '0);
    send_item(cwtc_pkg::FUNC_CORRECT, 8'd255, 24'd1, 24'hffffff, 32'sh80000000, '1);
    send_item(cwtc_pkg::FUNC_CORRECT, 8'd255, 24'hffffff, 24'd1, 32'sh7fffffff, '1);
    // zero charge on side a, side b and both, then a small nonzero pair
    send_item(cwtc_pkg::FUNC_CORRECT, 8'd0, '0, 24'd5, 32'sh7fffffff, '0);
    send_item(cwtc_pkg::FUNC_CORRECT, 8'd0, 24'd5, '0, 32'sh80000000, '0);
    send_item(cwtc_pkg::FUNC_CORRECT, 8'd0, '0, '0, 32'sd12345, '0);
    send_item(cwtc_pkg::FUNC_CORRECT, 8'd7, 24'd4, 24'd9, 32'sd0, '0);
    // equal charges, then unequal ones
    send_item(cwtc_pkg::FUNC_CORRECT, 8'd7, 24'd1234, 24'd1234, -32'sd77, '0);
    send_item(cwtc_pkg::FUNC_CORRECT, 8'd7, 24'd2, 24'd3, 32'sd5, '0);
    send_item(cwtc_pkg::FUNC_CORRECT, 8'd255, 24'd100, 24'd200, 32'sd0, '0);

    // random: loads seed the table, correct items come in hit pairs
    for (int n = 0; n < 480; n++) begin
      calm_stretch = (n >= 200 && n < 280);
      pm = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      if ($urandom_range(0, 4) == 0) begin
        send_item(cwtc_pkg::FUNC_LOAD, pm, pick_charge(), pick_charge(), pick_word(),
                  pick_word());
      end else begin
        qa = pick_charge();
        qb = pick_charge();
        send_item(cwtc_pkg::FUNC_CORRECT, pm, qa, qb, pick_word(), pick_word());
        // the partner hit of the line of response, charges swapped
        send_item(cwtc_pkg::FUNC_CORRECT, pm, qb, qa, pick_word(), pick_word());
        n++;
      end
    end
    calm_stretch = 1'b0;
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d correct and %0d load items, %0d results checked",
             hit_items, load_items, result_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* charge_walk_time_correction_core.f */
hdl/cwtc_pkg.sv
hdl/cwtc_coef_mem.sv
hdl/cwtc_inv_sqrt.sv
hdl/cwtc_post.sv
hdl/charge_walk_time_correction_core.sv
hdl/cwtc_checker.sv
dv/charge_walk_time_correction_checker.sv
dv/charge_walk_time_correction_core_tb.sv
